FILE: src/soc_debug_policy_controller_core_defines.svh
// ----------------------------------------------------------------------------
// soc_debug_policy_controller_core_defines.svh
// Assertion macros used by the debug-policy controller checker.
// ----------------------------------------------------------------------------
`ifndef SOC_DEBUG_POLICY_CONTROLLER_CORE_DEFINES_SVH
`define SOC_DEBUG_POLICY_CONTROLLER_CORE_DEFINES_SVH

// Same-cycle implication on aclk, disabled while aresetn is low.
`define SDPC_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on aclk, disabled while aresetn is low.
`define SDPC_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/sdpc_pkg.sv
// ----------------------------------------------------------------------------
// sdpc_pkg
// Types, command codes and register offsets of the debug-policy controller.
// ----------------------------------------------------------------------------
package sdpc_pkg;

    // command codes (carried on s_tuser)
    localparam logic [3:0] CMD_CORE_RD   = 4'd0;
    localparam logic [3:0] CMD_CORE_WR   = 4'd1;
    localparam logic [3:0] CMD_DBG_RD    = 4'd2;
    localparam logic [3:0] CMD_DBG_WR    = 4'd3;
    localparam logic [3:0] CMD_PIN_A0    = 4'd4;
    localparam logic [3:0] CMD_PIN_HALT  = 4'd5;
    localparam logic [3:0] CMD_PIN_RAW   = 4'd6;
    localparam logic [3:0] CMD_LC_RTR    = 4'd7;
    localparam logic [3:0] CMD_LC_DFT    = 4'd8;
    localparam logic [3:0] CMD_LC_HWDBG  = 4'd9;
    localparam logic [3:0] CMD_LC_CPU    = 4'd10;
    localparam logic [3:0] CMD_BOOT_STAT = 4'd11;
    localparam logic [3:0] CMD_LC_MODE   = 4'd12;
    localparam logic [3:0] CMD_TICK      = 4'd13;

    // core-bus offsets
    localparam logic [2:0] CORE_IRQ_STATUS = 3'd0;
    localparam logic [2:0] CORE_INTR_EN    = 3'd1;
    localparam logic [2:0] CORE_IRQ_TEST   = 3'd2;
    localparam logic [2:0] CORE_FATAL_TEST = 3'd3;
    localparam logic [2:0] CORE_POL_CTRL   = 3'd4;
    localparam logic [2:0] CORE_POL_VALID  = 3'd5;
    localparam logic [2:0] CORE_MAILBOX    = 3'd6;

    // debug-bus offsets
    localparam logic [2:0] DBG_CONTROL     = 3'd0;
    localparam logic [2:0] DBG_STATUS      = 3'd1;
    localparam logic [2:0] DBG_BOOT_STATUS = 3'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_LOCKED   = 2'd0;
    localparam logic [1:0] CFG_UNLOCKED = 2'd1;
    localparam logic [1:0] CFG_IGN_TEST = 2'd2;

    // lifecycle modes
    localparam logic [1:0] MODE_RAW  = 2'd0;
    localparam logic [1:0] MODE_PRE  = 2'd1;
    localparam logic [1:0] MODE_PROD = 2'd2;

    localparam logic [15:0] MBX_MASK      = 16'hFFF1;
    localparam logic [11:0] BOOT_MASK     = 12'hB7F;
    localparam logic [11:0] BOOT_RST      = 12'h300;
    localparam int          BOOT_LC_DONE  = 4;
    localparam logic [2:0]  LOCKED_RST    = 3'd7;
    localparam logic [2:0]  UNLOCKED_RST  = 3'd0;

    // bit positions in the pin and lifecycle vectors
    localparam int PIN_A0   = 0;
    localparam int PIN_RAW  = 1;
    localparam int PIN_HALT = 2;
    localparam int LC_RTR   = 0;
    localparam int LC_DFT   = 1;
    localparam int LC_HWDBG = 2;
    localparam int LC_CPU   = 3;

    typedef enum logic [2:0] {
        BOOT_IDLE      = 3'd0,
        BOOT_CHECK_LC  = 3'd1,
        BOOT_WAIT_DFT  = 3'd2,
        BOOT_CHECK_PIN = 3'd3,
        BOOT_WAIT_GO   = 3'd4,
        BOOT_CONTINUE  = 3'd5,
        BOOT_DONE      = 3'd6
    } boot_state_t;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [2:0]  reg_index;
        logic [31:0] write_data;
        logic        signal_level;
        logic [11:0] boot_status_word;
        logic [1:0]  lifecycle_mode;
    } item_t;

    typedef struct packed {
        logic [2:0]  boot_fsm_state;
        logic        boot_done;
        logic        policy_valid;
        logic [2:0]  policy_level;
        logic        alert_level;
        logic        irq_level;
        logic        access_error;
        logic [31:0] read_data;
    } result_t;

    typedef struct packed {
        logic [2:0] locked_policy;
        logic [2:0] unlocked_policy;
        logic       ignore_test_mode;
    } cfg_t;

    // inputs to the boot-halt machine
    typedef struct packed {
        logic lc_done;
        logic lc_rtr;
        logic lc_dft;
        logic halt_pin;
        logic go_req;
        logic ignore_test_mode;
    } fsm_in_t;

    // next values seen by the result path
    typedef struct packed {
        boot_state_t state;
        logic        done;
        logic        alert_set;
    } fsm_out_t;

endpackage

FILE: src/sdpc_boot_fsm.sv
// ----------------------------------------------------------------------------
// sdpc_boot_fsm
// Seven-state boot-halt machine, advanced one step per tick item.
// ----------------------------------------------------------------------------
module sdpc_boot_fsm (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  sdpc_pkg::fsm_in_t fsm_in,
    output sdpc_pkg::fsm_out_t fsm_out
);

    sdpc_pkg::boot_state_t state_reg, state_next;
    logic                  done_reg, done_next;
    logic                  alert_set;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sdpc_pkg::BOOT_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        done_next  = done_reg;
        alert_set  = 1'b0;
        if (step) begin
            done_next = 1'b0;
            case (state_reg)
                sdpc_pkg::BOOT_IDLE: begin
                    if (fsm_in.lc_done) state_next = sdpc_pkg::BOOT_CHECK_LC;
                end
                sdpc_pkg::BOOT_CHECK_LC: begin
                    state_next = (fsm_in.lc_rtr && !fsm_in.ignore_test_mode)
                               ? sdpc_pkg::BOOT_WAIT_DFT : sdpc_pkg::BOOT_CONTINUE;
                end
                sdpc_pkg::BOOT_WAIT_DFT: begin
                    if (fsm_in.lc_dft) state_next = sdpc_pkg::BOOT_CHECK_PIN;
                end
                sdpc_pkg::BOOT_CHECK_PIN: begin
                    state_next = fsm_in.halt_pin ? sdpc_pkg::BOOT_WAIT_GO
                                                 : sdpc_pkg::BOOT_CONTINUE;
                end
                sdpc_pkg::BOOT_WAIT_GO: begin
                    if (fsm_in.go_req) state_next = sdpc_pkg::BOOT_CONTINUE;
                end
                sdpc_pkg::BOOT_CONTINUE: begin
                    state_next = sdpc_pkg::BOOT_DONE;
                end
                sdpc_pkg::BOOT_DONE: begin
                    done_next = 1'b1;
                end
                default: begin
                    // lost state: raise the alert, hold state and done level
                    done_next = done_reg;
                    alert_set = 1'b1;
                end
            endcase
        end
    end

    assign fsm_out.state     = state_next;
    assign fsm_out.done      = done_next;
    assign fsm_out.alert_set = alert_set;

endmodule

FILE: src/sdpc_core.sv
// ----------------------------------------------------------------------------
// sdpc_core
// Register file, signal tracking and policy logic; executes one item per step.
// ----------------------------------------------------------------------------
module sdpc_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  sdpc_pkg::item_t   item,
    input  sdpc_pkg::cfg_t    cfg,
    output sdpc_pkg::result_t result
);

    logic        intr_status_reg, intr_status_next;
    logic        intr_enable_reg, intr_enable_next;
    logic [3:0]  pol_ctrl_reg, pol_ctrl_next;
    logic        pol_valid_reg, pol_valid_next;
    logic [15:0] mailbox_reg, mailbox_next;
    logic [2:0]  pins_reg, pins_next;
    logic [3:0]  lc_reg, lc_next;
    logic [11:0] boot_stat_reg, boot_stat_next;
    logic [1:0]  mode_reg, mode_next;
    logic [2:0]  policy_reg, policy_next;
    logic        cur_valid_reg, cur_valid_next;
    logic        continue_reg, continue_next;
    logic        alert_reg, alert_next;

    logic [31:0] rdata;
    logic        err;
    logic        tick;
    logic [1:0]  eff_mode;

    sdpc_pkg::fsm_in_t  fsm_in;
    sdpc_pkg::fsm_out_t fsm_out;

    assign tick = step && (item.cmd == sdpc_pkg::CMD_TICK);

    assign fsm_in.lc_done          = boot_stat_reg[sdpc_pkg::BOOT_LC_DONE];
    assign fsm_in.lc_rtr           = lc_reg[sdpc_pkg::LC_RTR];
    assign fsm_in.lc_dft           = lc_reg[sdpc_pkg::LC_DFT];
    assign fsm_in.halt_pin         = pins_reg[sdpc_pkg::PIN_HALT];
    assign fsm_in.go_req           = continue_reg;
    assign fsm_in.ignore_test_mode = cfg.ignore_test_mode;

    sdpc_boot_fsm u_boot_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (tick),
        .fsm_in  (fsm_in),
        .fsm_out (fsm_out)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            intr_status_reg <= 1'b0;
            intr_enable_reg <= 1'b0;
            pol_ctrl_reg    <= '0;
            pol_valid_reg   <= 1'b0;
            mailbox_reg     <= '0;
            pins_reg        <= '0;
            lc_reg          <= '0;
            boot_stat_reg   <= sdpc_pkg::BOOT_RST;
            mode_reg        <= sdpc_pkg::MODE_PROD;
            policy_reg      <= sdpc_pkg::LOCKED_RST;
            cur_valid_reg   <= 1'b0;
            continue_reg    <= 1'b0;
            alert_reg       <= 1'b0;
        end else if (step) begin
            intr_status_reg <= intr_status_next;
            intr_enable_reg <= intr_enable_next;
            pol_ctrl_reg    <= pol_ctrl_next;
            pol_valid_reg   <= pol_valid_next;
            mailbox_reg     <= mailbox_next;
            pins_reg        <= pins_next;
            lc_reg          <= lc_next;
            boot_stat_reg   <= boot_stat_next;
            mode_reg        <= mode_next;
            policy_reg      <= policy_next;
            cur_valid_reg   <= cur_valid_next;
            continue_reg    <= continue_next;
            alert_reg       <= alert_next;
        end
    end

    // raw mode is forced while both a0 debug and force-raw pins are high
    assign eff_mode = (pins_reg[sdpc_pkg::PIN_A0] && pins_reg[sdpc_pkg::PIN_RAW])
                    ? sdpc_pkg::MODE_RAW : mode_reg;

    always_comb begin
        intr_status_next = intr_status_reg;
        intr_enable_next = intr_enable_reg;
        pol_ctrl_next    = pol_ctrl_reg;
        pol_valid_next   = pol_valid_reg;
        mailbox_next     = mailbox_reg;
        pins_next        = pins_reg;
        lc_next          = lc_reg;
        boot_stat_next   = boot_stat_reg;
        mode_next        = mode_reg;
        policy_next      = policy_reg;
        cur_valid_next   = cur_valid_reg;
        continue_next    = continue_reg;
        alert_next       = alert_reg | fsm_out.alert_set;
        rdata            = '0;
        err              = 1'b0;

        case (item.cmd)
            sdpc_pkg::CMD_CORE_RD: begin
                case (item.reg_index)
                    sdpc_pkg::CORE_IRQ_STATUS: rdata = {31'd0, intr_status_reg};
                    sdpc_pkg::CORE_INTR_EN:    rdata = {31'd0, intr_enable_reg};
                    sdpc_pkg::CORE_POL_CTRL:   rdata = {28'd0, pol_ctrl_reg};
                    sdpc_pkg::CORE_POL_VALID:  rdata = {31'd0, pol_valid_reg};
                    sdpc_pkg::CORE_MAILBOX:    rdata = {16'd0, mailbox_reg};
                    default:                   err   = 1'b1;
                endcase
            end
            sdpc_pkg::CMD_CORE_WR: begin
                case (item.reg_index)
                    sdpc_pkg::CORE_IRQ_STATUS:
                        intr_status_next = intr_status_reg & ~item.write_data[0];
                    sdpc_pkg::CORE_INTR_EN:    intr_enable_next = item.write_data[0];
                    sdpc_pkg::CORE_IRQ_TEST:
                        intr_status_next = intr_status_reg | item.write_data[0];
                    sdpc_pkg::CORE_FATAL_TEST:
                        alert_next = alert_reg | item.write_data[0];
                    sdpc_pkg::CORE_POL_CTRL:   pol_ctrl_next  = item.write_data[3:0];
                    sdpc_pkg::CORE_POL_VALID:  pol_valid_next = item.write_data[0];
                    sdpc_pkg::CORE_MAILBOX:
                        mailbox_next = item.write_data[15:0] & sdpc_pkg::MBX_MASK;
                    default:                   err = 1'b1;
                endcase
            end
            sdpc_pkg::CMD_DBG_RD: begin
                if (item.reg_index == sdpc_pkg::DBG_CONTROL) begin
                    rdata = {31'd0, continue_reg};
                end else if (item.reg_index == sdpc_pkg::DBG_STATUS) begin
                    rdata = {16'd0, mailbox_reg};
                end else if (item.reg_index == sdpc_pkg::DBG_BOOT_STATUS &&
                             lc_reg[sdpc_pkg::LC_DFT]) begin
                    rdata = {20'd0, boot_stat_reg};
                end else begin
                    err = 1'b1;
                end
            end
            sdpc_pkg::CMD_DBG_WR: begin
                if (item.reg_index == sdpc_pkg::DBG_CONTROL) begin
                    continue_next = item.write_data[0];
                end else begin
                    err = 1'b1;
                end
            end
            sdpc_pkg::CMD_PIN_A0:    pins_next[sdpc_pkg::PIN_A0]   = item.signal_level;
            sdpc_pkg::CMD_PIN_HALT:  pins_next[sdpc_pkg::PIN_HALT] = item.signal_level;
            sdpc_pkg::CMD_PIN_RAW:   pins_next[sdpc_pkg::PIN_RAW]  = item.signal_level;
            sdpc_pkg::CMD_LC_RTR:    lc_next[sdpc_pkg::LC_RTR]   = item.signal_level;
            sdpc_pkg::CMD_LC_DFT:    lc_next[sdpc_pkg::LC_DFT]   = item.signal_level;
            sdpc_pkg::CMD_LC_HWDBG:  lc_next[sdpc_pkg::LC_HWDBG] = item.signal_level;
            sdpc_pkg::CMD_LC_CPU:    lc_next[sdpc_pkg::LC_CPU]   = item.signal_level;
            sdpc_pkg::CMD_BOOT_STAT:
                boot_stat_next = item.boot_status_word & sdpc_pkg::BOOT_MASK;
            sdpc_pkg::CMD_LC_MODE:   mode_next = item.lifecycle_mode;
            sdpc_pkg::CMD_TICK: begin
                case (eff_mode)
                    sdpc_pkg::MODE_RAW: begin
                        policy_next = (lc_reg[sdpc_pkg::LC_DFT] ||
                                       lc_reg[sdpc_pkg::LC_HWDBG] ||
                                       pins_reg[sdpc_pkg::PIN_A0])
                                    ? cfg.unlocked_policy : cfg.locked_policy;
                        cur_valid_next = boot_stat_reg[sdpc_pkg::BOOT_LC_DONE] ||
                                         pins_reg[sdpc_pkg::PIN_A0];
                    end
                    sdpc_pkg::MODE_PRE: begin
                        policy_next    = cfg.unlocked_policy;
                        cur_valid_next = boot_stat_reg[sdpc_pkg::BOOT_LC_DONE];
                    end
                    sdpc_pkg::MODE_PROD: begin
                        policy_next    = pol_ctrl_reg[2:0];
                        cur_valid_next = pol_valid_reg;
                    end
                    default: begin
                        policy_next    = cfg.locked_policy;
                        cur_valid_next = 1'b0;
                    end
                endcase
            end
            default: ;
        endcase
    end

    assign result.read_data      = rdata;
    assign result.access_error   = err;
    assign result.irq_level      = intr_status_next & intr_enable_next;
    assign result.alert_level    = alert_next;
    assign result.policy_level   = policy_next;
    assign result.policy_valid   = cur_valid_next;
    assign result.boot_done      = fsm_out.done;
    assign result.boot_fsm_state = fsm_out.state;

endmodule

FILE: src/soc_debug_policy_controller_core.sv
// ----------------------------------------------------------------------------
// soc_debug_policy_controller_core
// Debug-policy controller: bus registers, pin and lifecycle tracking,
// debug policy and boot-halt machine, one result item per input item.
// ----------------------------------------------------------------------------
//  channel  | ports                   | payload
//  ---------+-------------------------+--------------------------------------
//  input    | s_tvalid/s_tready       | s_tuser: cmd; s_tdata: bus/event data
//  result   | m_tvalid/m_tready       | m_tdata: read data, flags, status
//  config   | cfg_wr_en               | cfg_addr index, cfg_wdata value
//
// An item lands in the input register, then its execution (state update
// plus result) is written to the output register. Throughput is one item
// per cycle while the result is not stalled; the input register refills in
// the same cycle its item moves to the output register.
// A stalled result holds m_tdata; one more item waits in the input register.
// Reset is synchronous, active low; policy resets to the locked value (7).
// ----------------------------------------------------------------------------
module soc_debug_policy_controller_core (
    input  logic        aclk,
    input  logic        aresetn,
    // input item
    input  logic        s_tvalid,
    output logic        s_tready,
    // [3:0] cmd
    input  logic [3:0]  s_tuser,
    // [2:0] reg_index, [34:3] write_data, [35] signal_level,
    // [47:36] boot_status_word, [49:48] lifecycle_mode, [55:50] zero
    input  logic [55:0] s_tdata,
    // result item
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] read_data, [32] access_error, [33] irq_level, [34] alert_level,
    // [37:35] policy_level, [38] policy_valid, [39] boot done level,
    // [42:40] boot_fsm_state, [47:43] zero
    output logic [47:0] m_tdata,
    // configuration writes
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [2:0]  cfg_wdata
);

    logic              in_vld_reg;
    sdpc_pkg::item_t   in_item_reg;
    logic              out_vld_reg;
    sdpc_pkg::result_t out_res_reg;
    sdpc_pkg::cfg_t    cfg_reg;
    sdpc_pkg::result_t core_res;
    logic              out_free;
    logic              fire;
    logic              s_accept;

    assign out_free = !out_vld_reg || m_tready;
    assign fire     = in_vld_reg && out_free;
    assign s_tready = !in_vld_reg || out_free;
    assign s_accept = s_tvalid && s_tready;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_accept) begin
            in_vld_reg <= 1'b1;
        end else if (fire) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg.cmd              <= s_tuser;
            in_item_reg.reg_index        <= s_tdata[2:0];
            in_item_reg.write_data       <= s_tdata[34:3];
            in_item_reg.signal_level     <= s_tdata[35];
            in_item_reg.boot_status_word <= s_tdata[47:36];
            in_item_reg.lifecycle_mode   <= s_tdata[49:48];
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.locked_policy    <= sdpc_pkg::LOCKED_RST;
            cfg_reg.unlocked_policy  <= sdpc_pkg::UNLOCKED_RST;
            cfg_reg.ignore_test_mode <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                sdpc_pkg::CFG_LOCKED:   cfg_reg.locked_policy    <= cfg_wdata;
                sdpc_pkg::CFG_UNLOCKED: cfg_reg.unlocked_policy  <= cfg_wdata;
                sdpc_pkg::CFG_IGN_TEST: cfg_reg.ignore_test_mode <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // execution: state updates commit on fire
    sdpc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (fire),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .result  (core_res)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (fire) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {5'd0, out_res_reg};

endmodule

FILE: src/sdpc_checker.sv
// ----------------------------------------------------------------------------
// sdpc_checker
// Port-level checks on the result channel of the debug-policy controller.
// ----------------------------------------------------------------------------
`include "soc_debug_policy_controller_core_defines.svh"

module sdpc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    logic       stall;
    logic       done_out;
    logic       err_out;
    logic [2:0] state;

    assign stall    = m_tvalid && !m_tready;
    assign done_out = m_tvalid && m_tdata[39];
    assign err_out  = m_tvalid && m_tdata[32];
    assign state    = m_tdata[42:40];

    // stalled result holds
    `SDPC_ASSERT_NXT(a_hold, stall, m_tvalid && $stable(m_tdata), "stalled result changed")

    // boot machine never shows a lost state
    `SDPC_ASSERT_IMP(a_state, m_tvalid, state <= sdpc_pkg::BOOT_DONE, "boot state out of range")

    // boot done only in the done state
    `SDPC_ASSERT_IMP(a_done, done_out, state == sdpc_pkg::BOOT_DONE, "done outside done state")

    // rejected access returns zero data
    `SDPC_ASSERT_IMP(a_err, err_out, m_tdata[31:0] == 32'd0, "error with nonzero read data")

endmodule

bind soc_debug_policy_controller_core sdpc_checker u_sdpc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for soc_debug_policy_controller_core. Items go in
// on the s_ stream and each one is run through a cycle-free copy of the
// controller (bus registers, pins, lifecycle signals, policy and boot-halt
// machine). The result item it produces is queued and compared field by
// field with the m_ stream. A directed pass comes first, then random
// traffic under four idling patterns and several policy settings.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT  = 200000;  // far above the slowest legal run
    localparam int DRAIN_CYCLES = 4;       // input and output registers plus margin
    localparam int PHASE_ITEMS  = 340;     // four phases, 1360 random items

    localparam logic [2:0] BAD_OFFSET = 3'd7;   // past both register files
    localparam logic [1:0] MODE_UNDEF = 2'd3;   // no lifecycle mode uses it
    localparam logic [3:0] CMD_SPARE  = 4'd15;  // no command uses it

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [3:0]  s_tuser;
    logic [55:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        cfg_wr_en;
    logic [1:0]  cfg_addr;
    logic [2:0]  cfg_wdata;

    soc_debug_policy_controller_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // clock, watchdog
    // ------------------------------------------------------------------
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    int cycle_count = 0;
    int failures    = 0;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL soc_debug_policy_controller_core");
            $finish;
        end
    end

    // idling pattern of the current phase, in percent of cycles
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // ------------------------------------------------------------------
    // Controller mirror. Updated once per accepted item, in item order.
    // ------------------------------------------------------------------
    logic [2:0]            cfg_locked;
    logic [2:0]            cfg_unlocked;
    logic                  cfg_ign_test;

    logic                  intr_st;
    logic                  intr_en;
    logic [3:0]            pol_ctrl;
    logic                  pol_valid;
    logic [15:0]           mailbox;
    sdpc_pkg::boot_state_t boot_st;
    logic [2:0]            pins;      // a0 debug, force raw, halt
    logic [3:0]            lc;        // raw-test-rma, dft-en, hw-debug-en, cpu-en
    logic [11:0]           boot_word;
    logic [1:0]            lc_mode;
    logic [2:0]            cur_pol;
    logic                  cur_valid;
    logic                  go_flag;   // debug control bit 0, boot continue
    logic                  alert;
    logic                  done_lvl;

    sdpc_pkg::result_t replies_owed[$];

    task automatic reset_mirror();
        cfg_locked   = sdpc_pkg::LOCKED_RST;
        cfg_unlocked = sdpc_pkg::UNLOCKED_RST;
        cfg_ign_test = 1'b0;
        intr_st      = 1'b0;
        intr_en      = 1'b0;
        pol_ctrl     = 4'd0;
        pol_valid    = 1'b0;
        mailbox      = 16'd0;
        boot_st      = sdpc_pkg::BOOT_IDLE;
        pins         = 3'd0;
        lc           = 4'd0;
        boot_word    = sdpc_pkg::BOOT_RST;
        lc_mode      = sdpc_pkg::MODE_PROD;
        cur_pol      = sdpc_pkg::LOCKED_RST;
        cur_valid    = 1'b0;
        go_flag      = 1'b0;
        alert        = 1'b0;
        done_lvl     = 1'b0;
    endtask

    // Runs one item through the mirror and returns the result it causes.
    function automatic sdpc_pkg::result_t compute_reply(input sdpc_pkg::item_t it);
        sdpc_pkg::result_t r;
        logic [1:0]        eff_mode;
        logic              reached_done;
        logic              lost_state;
        logic [31:0]       wd;
        r            = '0;
        wd           = it.write_data;
        reached_done = 1'b0;
        lost_state   = 1'b0;
        case (it.cmd)
            sdpc_pkg::CMD_CORE_RD: begin
                case (it.reg_index)
                    sdpc_pkg::CORE_IRQ_STATUS: r.read_data = {31'd0, intr_st};
                    sdpc_pkg::CORE_INTR_EN:    r.read_data = {31'd0, intr_en};
                    sdpc_pkg::CORE_POL_CTRL:   r.read_data = {28'd0, pol_ctrl};
                    sdpc_pkg::CORE_POL_VALID:  r.read_data = {31'd0, pol_valid};
                    sdpc_pkg::CORE_MAILBOX:    r.read_data = {16'd0, mailbox};
                    default: r.access_error = 1'b1;  // write-only or bad offset
                endcase
            end
            sdpc_pkg::CMD_CORE_WR: begin
                case (it.reg_index)
                    sdpc_pkg::CORE_IRQ_STATUS: intr_st = intr_st & ~wd[0];  // W1C
                    sdpc_pkg::CORE_INTR_EN:    intr_en = wd[0];
                    sdpc_pkg::CORE_IRQ_TEST:   intr_st = intr_st | wd[0];
                    sdpc_pkg::CORE_FATAL_TEST: if (wd[0]) alert = 1'b1;
                    sdpc_pkg::CORE_POL_CTRL:   pol_ctrl = wd[3:0];
                    sdpc_pkg::CORE_POL_VALID:  pol_valid = wd[0];
                    sdpc_pkg::CORE_MAILBOX:    mailbox = wd[15:0] & sdpc_pkg::MBX_MASK;
                    default:                   r.access_error = 1'b1;
                endcase
            end
            sdpc_pkg::CMD_DBG_RD: begin
                if (it.reg_index == sdpc_pkg::DBG_CONTROL)
                    r.read_data = {31'd0, go_flag};
                else if (it.reg_index == sdpc_pkg::DBG_STATUS)
                    r.read_data = {16'd0, mailbox};
                else if (it.reg_index == sdpc_pkg::DBG_BOOT_STATUS &&
                         lc[sdpc_pkg::LC_DFT])
                    r.read_data = {20'd0, boot_word};
                else
                    r.access_error = 1'b1;  // gated boot status or bad offset
            end
            sdpc_pkg::CMD_DBG_WR: begin
                if (it.reg_index == sdpc_pkg::DBG_CONTROL) go_flag = wd[0];
                else r.access_error = 1'b1;
            end
            sdpc_pkg::CMD_PIN_A0:   pins[sdpc_pkg::PIN_A0]   = it.signal_level;
            sdpc_pkg::CMD_PIN_HALT: pins[sdpc_pkg::PIN_HALT] = it.signal_level;
            sdpc_pkg::CMD_PIN_RAW:  pins[sdpc_pkg::PIN_RAW]  = it.signal_level;
            sdpc_pkg::CMD_LC_RTR, sdpc_pkg::CMD_LC_DFT,
            sdpc_pkg::CMD_LC_HWDBG, sdpc_pkg::CMD_LC_CPU:
                lc[2'(it.cmd - sdpc_pkg::CMD_LC_RTR)] = it.signal_level;
            sdpc_pkg::CMD_BOOT_STAT: boot_word = it.boot_status_word & sdpc_pkg::BOOT_MASK;
            sdpc_pkg::CMD_LC_MODE:   lc_mode = it.lifecycle_mode;
            sdpc_pkg::CMD_TICK: begin
                // policy first: both debug pins high force raw mode
                eff_mode = (pins[sdpc_pkg::PIN_A0] && pins[sdpc_pkg::PIN_RAW])
                           ? sdpc_pkg::MODE_RAW : lc_mode;
                case (eff_mode)
                    sdpc_pkg::MODE_RAW: begin
                        cur_pol = (lc[sdpc_pkg::LC_DFT] || lc[sdpc_pkg::LC_HWDBG] ||
                                   pins[sdpc_pkg::PIN_A0]) ? cfg_unlocked : cfg_locked;
                        cur_valid = boot_word[sdpc_pkg::BOOT_LC_DONE] ||
                                    pins[sdpc_pkg::PIN_A0];
                    end
                    sdpc_pkg::MODE_PRE: begin
                        cur_pol   = cfg_unlocked;
                        cur_valid = boot_word[sdpc_pkg::BOOT_LC_DONE];
                    end
                    sdpc_pkg::MODE_PROD: begin
                        cur_pol   = pol_ctrl[2:0];
                        cur_valid = pol_valid;
                    end
                    default: begin
                        cur_pol   = cfg_locked;
                        cur_valid = 1'b0;
                    end
                endcase
                // then one step of the boot-halt machine
                case (boot_st)
                    sdpc_pkg::BOOT_IDLE:
                        if (boot_word[sdpc_pkg::BOOT_LC_DONE])
                            boot_st = sdpc_pkg::BOOT_CHECK_LC;
                    sdpc_pkg::BOOT_CHECK_LC:
                        boot_st = (lc[sdpc_pkg::LC_RTR] && !cfg_ign_test)
                                  ? sdpc_pkg::BOOT_WAIT_DFT : sdpc_pkg::BOOT_CONTINUE;
                    sdpc_pkg::BOOT_WAIT_DFT:
                        if (lc[sdpc_pkg::LC_DFT]) boot_st = sdpc_pkg::BOOT_CHECK_PIN;
                    sdpc_pkg::BOOT_CHECK_PIN:
                        boot_st = pins[sdpc_pkg::PIN_HALT] ? sdpc_pkg::BOOT_WAIT_GO
                                                           : sdpc_pkg::BOOT_CONTINUE;
                    sdpc_pkg::BOOT_WAIT_GO:
                        if (go_flag) boot_st = sdpc_pkg::BOOT_CONTINUE;
                    sdpc_pkg::BOOT_CONTINUE:
                        boot_st = sdpc_pkg::BOOT_DONE;
                    sdpc_pkg::BOOT_DONE:
                        reached_done = 1'b1;
                    default: begin
                        alert      = 1'b1;
                        lost_state = 1'b1;
                    end
                endcase
                if (!lost_state) done_lvl = reached_done;
            end
            default: ;  // unused command codes change nothing
        endcase
        r.irq_level      = intr_st & intr_en;
        r.alert_level    = alert;
        r.policy_level   = cur_pol;
        r.policy_valid   = cur_valid;
        r.boot_done      = done_lvl;
        r.boot_fsm_state = boot_st;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stream drivers: inputs move on the falling edge
    // ------------------------------------------------------------------
    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = 4'd0;
        s_tdata   = 56'd0;
        m_tready  = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = 2'd0;
        cfg_wdata = 3'd0;
    end

    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Offers one item, with random idle cycles ahead of it, and books its
    // result once the handshake completes. tvalid stays high between
    // back-to-back items.
    task automatic send_item(input sdpc_pkg::item_t it);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.cmd;
        s_tdata  <= {6'd0, it.lifecycle_mode, it.boot_status_word,
                     it.signal_level, it.write_data, it.reg_index};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        replies_owed.push_back(compute_reply(it));
    endtask

    function automatic sdpc_pkg::item_t item_of(input logic [3:0] cmd,
                                                input logic [2:0] idx,
                                                input logic [31:0] wd,
                                                input logic lvl,
                                                input logic [11:0] bw,
                                                input logic [1:0] md);
        sdpc_pkg::item_t it;
        it.cmd              = cmd;
        it.reg_index        = idx;
        it.write_data       = wd;
        it.signal_level     = lvl;
        it.boot_status_word = bw;
        it.lifecycle_mode   = md;
        return it;
    endfunction

    // Drops tvalid and waits until every booked result has come back.
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (replies_owed.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic [1:0] addr, input logic [2:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (addr)
            sdpc_pkg::CFG_LOCKED:   cfg_locked   = val;
            sdpc_pkg::CFG_UNLOCKED: cfg_unlocked = val;
            sdpc_pkg::CFG_IGN_TEST: cfg_ign_test = val[0];
            default: ;
        endcase
    endtask

    task automatic set_policy_cfg(input logic [2:0] locked, input logic [2:0] unlocked,
                                  input logic ign);
        drain();
        write_cfg(sdpc_pkg::CFG_LOCKED, locked);
        write_cfg(sdpc_pkg::CFG_UNLOCKED, unlocked);
        write_cfg(sdpc_pkg::CFG_IGN_TEST, {2'd0, ign});
    endtask

    // ------------------------------------------------------------------
    // result checking: outputs sampled at the rising edge
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
        end
    endtask

    always @(posedge aclk) begin : result_monitor
        sdpc_pkg::result_t got;
        sdpc_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[42:0];
            if (replies_owed.size() == 0) begin
                $error("result item 0x%0h arrived with none outstanding", m_tdata);
                failures++;
            end else begin
                want = replies_owed.pop_front();
                check_field("read_data",      want.read_data,      got.read_data);
                check_field("access_error",   want.access_error,   got.access_error);
                check_field("irq_level",      want.irq_level,      got.irq_level);
                check_field("alert_level",    want.alert_level,    got.alert_level);
                check_field("policy_level",   want.policy_level,   got.policy_level);
                check_field("policy_valid",   want.policy_valid,   got.policy_valid);
                check_field("boot_done",      want.boot_done,      got.boot_done);
                check_field("boot_fsm_state", want.boot_fsm_state, got.boot_fsm_state);
            end
        end
    end

    // ------------------------------------------------------------------
    // directed tests (reset configuration, no idling)
    // ------------------------------------------------------------------
    task automatic test_core_registers();
        send_item(item_of(sdpc_pkg::CMD_CORE_WR, sdpc_pkg::CORE_INTR_EN,
                          32'hFFFF_FFFF, 1'b0, 12'd0, sdpc_pkg::MODE_RAW));
        send_item(item_of(sdpc_pkg::CMD_CORE_WR, sdpc_pkg::CORE_IRQ_TEST,
                          32'h0000_0001, 1'b0, 12'd0, sdpc_pkg::MODE_RAW));
        send_item(item_of(sdpc_pkg::CMD_CORE_WR, sdpc_pkg::CORE_POL_CTRL,
                          32'hFFFF_FFFF, 1'b0, 12'd0, sdpc_pkg::MODE_RAW));
        send_item(item_of(sdpc_pkg::CMD_CORE_WR, sdpc_pkg::CORE_POL_VALID,
                          32'h0000_0001, 1'b0, 12'd0, sdpc_pkg::MODE_RAW));
        send_item(item_of(sdpc_pkg::CMD_CORE_WR, sdpc_pkg::CORE_MAILBOX,
                          32'hFFFF_FFFF, 1'b0, 12'd0, sdpc_pkg::MODE_RAW));
        // last offset is past the register file
        send_item(item_of(sdpc_pkg::CMD_CORE_WR, BAD_OFFSET,
                          32'hFFFF_FFFF, 1'b1, 12'hFFF, MODE_UNDEF));
        // intr test is write only; the last offset is a bad one
        send_item(item_of(sdpc_pkg::CMD_CORE_RD, sdpc_pkg::CORE_IRQ_STATUS,
                          32'd0, 1'b0, 12'd0, sdpc_pkg::MODE_RAW));
        send_item(item_of(sdpc_pkg::CMD_CORE_RD, sdpc_pkg::CORE_IRQ_TEST,
                          32'd0, 1'b0, 12'd0, sdpc_pkg::MODE_RAW));
        send_item(item_of(sdpc_pkg::CMD_CORE_RD, sdpc_pkg::CORE_POL_CTRL,
                          32'd0, 1'b0, 12'd0, sdpc_pkg::MODE_RAW));
        send_item(item_of(sdpc_pkg::CMD_CORE_RD, sdpc_pkg::CORE_MAILBOX,
                          32'd0, 1'b0, 12'd0, sdpc_pkg::MODE_RAW));
        send_item(item_of(sdpc_pkg::CMD_CORE_RD, BAD_OFFSET,
                          32'd0, 1'b0, 12'd0, sdpc_pkg::MODE_RAW));
    endtask

    task automatic test_debug_registers();
        send_item(item_of(sdpc_pkg::CMD_DBG_WR, sdpc_pkg::DBG_CONTROL,
                          32'hFFFF_FFFF, 1'b0, 12'd0, sdpc_pkg::MODE_RAW));
        send_item(item_of(sdpc_pkg::CMD_DBG_WR, sdpc_pkg::DBG_STATUS,
                          32'hFFFF_FFFF, 1'b0, 12'd0, sdpc_pkg::MODE_RAW));
        send_item(item_of(sdpc_pkg::CMD_DBG_RD, sdpc_pkg::DBG_CONTROL,
                          32'd0, 1'b0, 12'd0, sdpc_pkg::MODE_RAW));
        // boot status is gated while dft-en is low
        send_item(item_of(sdpc_pkg::CMD_DBG_RD, sdpc_pkg::DBG_BOOT_STATUS,
                          32'd0, 1'b0, 12'd0, sdpc_pkg::MODE_RAW));
        send_item(item_of(sdpc_pkg::CMD_DBG_RD, BAD_OFFSET,
                          32'd0, 1'b0, 12'd0, sdpc_pkg::MODE_RAW));
    endtask

    task automatic test_signal_events();
        // lc_done stays clear so the boot machine holds idle for now;
        // the rom-done and rom-good bits must be dropped on the way in
        send_item(item_of(sdpc_pkg::CMD_BOOT_STAT, 3'd0,
                          32'd0, 1'b0, 12'hFEF, sdpc_pkg::MODE_RAW));
        send_item(item_of(sdpc_pkg::CMD_LC_DFT, 3'd0,
                          32'd0, 1'b1, 12'd0, sdpc_pkg::MODE_RAW));
        send_item(item_of(sdpc_pkg::CMD_DBG_RD, sdpc_pkg::DBG_BOOT_STATUS,
                          32'd0, 1'b0, 12'd0, sdpc_pkg::MODE_RAW));
    endtask

    task automatic test_policy_modes();
        // production mode from reset
        send_item(item_of(sdpc_pkg::CMD_TICK, 3'd0, 32'd0, 1'b0, 12'd0, sdpc_pkg::MODE_RAW));
        send_item(item_of(sdpc_pkg::CMD_LC_MODE, 3'd0, 32'd0, 1'b0, 12'd0, MODE_UNDEF));
        send_item(item_of(sdpc_pkg::CMD_TICK, 3'd0, 32'd0, 1'b0, 12'd0, sdpc_pkg::MODE_RAW));
        // both debug pins high force raw mode on the next tick
        send_item(item_of(sdpc_pkg::CMD_PIN_A0, 3'd0, 32'd0, 1'b1, 12'd0, sdpc_pkg::MODE_RAW));
        send_item(item_of(sdpc_pkg::CMD_PIN_RAW, 3'd0, 32'd0, 1'b1, 12'd0, sdpc_pkg::MODE_RAW));
        send_item(item_of(sdpc_pkg::CMD_TICK, 3'd0, 32'd0, 1'b0, 12'd0, sdpc_pkg::MODE_RAW));
        send_item(item_of(CMD_SPARE, BAD_OFFSET, 32'hFFFF_FFFF, 1'b1, 12'hFFF, MODE_UNDEF));
    endtask

    // ------------------------------------------------------------------
    // random traffic
    // ------------------------------------------------------------------
    // Command mix leans on ticks, bus accesses and signal changes. Early
    // phases keep lc_done low and never set the sticky alert, so the
    // policy paths get a long run before the boot machine is let go.
    function automatic sdpc_pkg::item_t random_item(input bit late);
        sdpc_pkg::item_t it;
        int              pick;
        pick                = int'($urandom_range(99));
        it.reg_index        = 3'($urandom_range(7));
        it.write_data       = $urandom;
        it.signal_level     = 1'($urandom_range(1));
        it.boot_status_word = 12'($urandom_range(4095));
        it.lifecycle_mode   = 2'($urandom_range(3));
        if (pick < 18)      it.cmd = sdpc_pkg::CMD_TICK;
        else if (pick < 32) it.cmd = sdpc_pkg::CMD_CORE_WR;
        else if (pick < 42) it.cmd = sdpc_pkg::CMD_CORE_RD;
        else if (pick < 49) it.cmd = sdpc_pkg::CMD_DBG_RD;
        else if (pick < 56) it.cmd = sdpc_pkg::CMD_DBG_WR;
        else if (pick < 78)
            it.cmd = 4'($urandom_range(sdpc_pkg::CMD_LC_CPU, sdpc_pkg::CMD_PIN_A0));
        else if (pick < 85) it.cmd = sdpc_pkg::CMD_BOOT_STAT;
        else if (pick < 92) it.cmd = sdpc_pkg::CMD_LC_MODE;
        else                it.cmd = 4'($urandom_range(15));  // noise, unused codes too
        if (!late) begin
            it.boot_status_word[sdpc_pkg::BOOT_LC_DONE] = 1'b0;
            if (it.cmd == sdpc_pkg::CMD_CORE_WR &&
                it.reg_index == sdpc_pkg::CORE_FATAL_TEST)
                it.write_data[0] = 1'b0;
        end
        return it;
    endfunction

    task automatic run_random_phase(input int idle_pct, input int stall_pct,
                                    input bit late);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < PHASE_ITEMS; n++)
            send_item(random_item(late));
        drain();
    endtask

    task automatic test_random_traffic();
        set_policy_cfg(3'd0, 3'd7, 1'b1);   // extremes one way
        run_random_phase(0, 0, 1'b0);
        set_policy_cfg(3'd7, 3'd0, 1'b0);   // and the other
        run_random_phase(48, 0, 1'b0);
        set_policy_cfg(3'($urandom_range(7)), 3'($urandom_range(7)),
                       1'($urandom_range(1)));
        run_random_phase(0, 48, 1'b0);
        // boot machine and alert allowed to move from here on
        set_policy_cfg(3'($urandom_range(7)), 3'($urandom_range(7)),
                       1'($urandom_range(1)));
        run_random_phase(9, 9, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        reset_mirror();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_core_registers();
        test_debug_registers();
        test_signal_events();
        test_policy_modes();
        test_random_traffic();

        drain();
        if (failures == 0)
            $display("PASS soc_debug_policy_controller_core");
        else
            $display("FAIL soc_debug_policy_controller_core");
        $finish;
    end

endmodule

FILE: soc_debug_policy_controller_core.f
+incdir+src
src/sdpc_pkg.sv
src/sdpc_boot_fsm.sv
src/sdpc_core.sv
src/soc_debug_policy_controller_core.sv
src/sdpc_checker.sv
bench/testbench.sv
